[design/bpfa_pkg.sv]
// Shared types, codes and counter helpers for the bitmap page frame allocator.
// No dependencies; every other design file but bpfa_ram imports this package.
`default_nettype none

package bpfa_pkg;

    localparam int ADDR_W = 48;
    localparam int CNT_W  = 16;
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2,
        OP_MARK    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NOMEM     = 3'd1,
        STS_ZERO      = 3'd2,
        STS_UNALIGNED = 3'd3,
        STS_RANGE     = 3'd4,
        STS_DOUBLE    = 3'd5
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        logic [CNT_W-1:0]   page_count;
        logic [ADDR_W-1:0]  byte_size;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  base_addr;
        logic [CNT_W-1:0]   pages_changed;
        logic [CNT_W-1:0]   free_count;
        logic [CNT_W-1:0]   used_count;
        logic [CNT_W-1:0]   reserved_count;
    } rsp_t;

    // classified job handed from front to back
    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  start_pg;
        logic [ADDR_W-1:0]  end_pg;
        logic [CNT_W-1:0]   count;
        status_t            status;
        logic               skip;
    } job_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

endpackage

`default_nettype wire

[design/bpfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/bpfa_front.sv]
// Front end: accepts request beats, classifies them into jobs, two-entry queue.
// Depends on bpfa_pkg.
`default_nettype none

module bpfa_front #(
    parameter int PAGE_BITS = 12
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire bpfa_pkg::req_t  req,
    input  wire logic            clearing,
    output logic                 job_valid,
    output bpfa_pkg::job_t       job,
    input  wire logic            job_pop
);
    import bpfa_pkg::*;

    localparam logic [ADDR_W-1:0] OFS_MASK = ADDR_W'((49'd1 << PAGE_BITS) - 49'd1);

    job_t             cls;
    logic [ADDR_W-1:0] first_pg;
    logic [ADDR_W:0]   rsv_sum;
    logic [ADDR_W-1:0] rsv_pages;

    job_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;

    always_comb
    begin
        first_pg  = req.addr >> PAGE_BITS;
        rsv_sum   = {1'b0, req.byte_size} + {1'b0, OFS_MASK};
        rsv_pages = ADDR_W'(rsv_sum >> PAGE_BITS);
        cls.op       = req.op;
        cls.count    = req.page_count;
        cls.start_pg = first_pg;
        cls.end_pg   = first_pg + ADDR_W'(req.page_count);
        cls.status   = STS_OK;
        cls.skip     = 1'b0;
        unique case (req.op)
            OP_ALLOC:
            begin
                if (req.page_count == '0)
                begin
                    cls.status = STS_ZERO;
                    cls.skip   = 1'b1;
                end
            end
            OP_FREE:
            begin
                if (req.page_count == '0)
                begin
                    cls.skip = 1'b1;
                end
                else if (req.addr == '0)
                begin
                    // page zero fails, the rest are still freed
                    cls.status   = STS_ZERO;
                    cls.start_pg = ADDR_W'(1);
                    cls.end_pg   = ADDR_W'(req.page_count);
                end
                else if ((req.addr & OFS_MASK) != '0)
                begin
                    cls.status = STS_UNALIGNED;
                    cls.skip   = 1'b1;
                end
            end
            OP_RESERVE:
            begin
                cls.end_pg = first_pg + rsv_pages;
            end
            OP_MARK:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign req_stall = (fill_reg == 2'd2) || clearing;
    assign push      = req_valid && !req_stall;
    assign job_valid = (fill_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (job_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(job_pop);
        end
    end

endmodule

`default_nettype wire

[design/bpfa_back.sv]
// Back end: executes jobs against the word-wide page map and drives the result beat.
// Depends on bpfa_pkg and bpfa_ram.
`default_nettype none

module bpfa_back #(
    parameter int PAGE_TOTAL = 32768,
    parameter int PAGE_BITS  = 12
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    input  wire bpfa_pkg::job_t  job,
    output logic                 job_pop,
    output logic                 clearing,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output bpfa_pkg::rsp_t       rsp
);
    import bpfa_pkg::*;

    localparam int WORDS = (PAGE_TOTAL + WORD_W - 1) / WORD_W;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SP_W  = WA_W + BIT_W;
    localparam int RUN_W = (SP_W + 1 > CNT_W + 1) ? SP_W + 1 : CNT_W + 1;
    localparam logic [ADDR_W-1:0] PT = ADDR_W'(PAGE_TOTAL);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_PRD, S_PWAIT, S_PMOD, S_SRD, S_SWAIT, S_SEXAM, S_SBIT, S_FIN
    } state_t;

    state_t             state_reg;
    logic [WA_W-1:0]    clr_idx_reg;
    op_t                op_reg;
    status_t            status_reg;
    logic [ADDR_W-1:0]  pg_reg, end_reg;
    logic [CNT_W-1:0]   count_reg, changed_reg;
    logic [CNT_W-1:0]   free_reg, used_reg, rsvd_reg;
    logic [WORD_W-1:0]  buf_reg;
    logic [WA_W:0]      sw_reg;
    logic [BIT_W-1:0]   bidx_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [SP_W-1:0]    start_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               ram_we;
    logic [WA_W-1:0]    ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    // per-page update
    logic               bit_cur, bit_new, pm_last;
    logic [ADDR_W-1:0]  pg_inc;
    logic [WORD_W-1:0]  buf_mod;
    logic [WA_W-1:0]    pg_word;

    // scan helpers
    logic [RUN_W-1:0]   cnt_ext;
    logic [SP_W-1:0]    st_word, st_bit;
    logic [CNT_W:0]     used_sum;

    // granted run: bulk counter update
    logic               grant;
    logic [CNT_W-1:0]   free_dec, used_inc;

    assign pg_word = pg_reg[SP_W-1:BIT_W];
    assign pg_inc  = pg_reg + 1'b1;
    assign bit_cur = buf_reg[pg_reg[BIT_W-1:0]];
    assign cnt_ext = RUN_W'(count_reg);
    assign st_word = (run_reg == '0) ? {sw_reg[WA_W-1:0], {BIT_W{1'b0}}} : start_reg;
    assign st_bit  = (run_reg == '0) ? {sw_reg[WA_W-1:0], bidx_reg} : start_reg;
    assign used_sum = {1'b0, used_reg} + {1'b0, count_reg};
    assign grant    = (op_reg == OP_ALLOC) && (status_reg == STS_OK);
    assign free_dec = (free_reg > count_reg) ? free_reg - count_reg : '0;
    assign used_inc = used_sum[CNT_W] ? '1 : used_sum[CNT_W-1:0];

    always_comb
    begin
        unique case (op_reg)
            OP_ALLOC:   bit_new = 1'b1;
            OP_RESERVE: bit_new = 1'b1;
            OP_FREE:    bit_new = 1'b0;
            OP_MARK:    bit_new = 1'b0;
            default:    bit_new = bit_cur;
        endcase
        buf_mod = buf_reg;
        buf_mod[pg_reg[BIT_W-1:0]] = bit_new;
        pm_last = (pg_reg[BIT_W-1:0] == {BIT_W{1'b1}}) || (pg_inc == end_reg) || (pg_inc >= PT);

        ram_we    = 1'b0;
        ram_waddr = pg_word;
        ram_wdata = buf_mod;
        ram_raddr = pg_word;
        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '1;
            end
            S_PMOD:
            begin
                ram_we = pm_last;
            end
            S_SRD:
            begin
                ram_raddr = sw_reg[WA_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign clearing  = (state_reg == S_CLR);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    bpfa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WORDS)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_idx_reg   <= '0;
            free_reg      <= '0;
            used_reg      <= '0;
            rsvd_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_FIN))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == WA_W'(WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        op_reg      <= job.op;
                        pg_reg      <= job.start_pg;
                        end_reg     <= job.end_pg;
                        count_reg   <= job.count;
                        status_reg  <= job.status;
                        changed_reg <= '0;
                        run_reg     <= '0;
                        sw_reg      <= '0;
                        start_reg   <= '0;
                        if (job.skip)
                        begin
                            state_reg <= S_FIN;
                        end
                        else if (job.op == OP_ALLOC)
                        begin
                            state_reg <= S_SRD;
                        end
                        else
                        begin
                            state_reg <= S_PRD;
                        end
                    end
                end
                S_PRD:
                begin
                    if (pg_reg == end_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (pg_reg >= PT)
                    begin
                        if (op_reg == OP_FREE && status_reg == STS_OK)
                        begin
                            status_reg <= STS_RANGE;
                        end
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_PWAIT;
                    end
                end
                S_PWAIT:
                begin
                    buf_reg   <= ram_rdata;
                    state_reg <= S_PMOD;
                end
                S_PMOD:
                begin
                    buf_reg <= buf_mod;
                    pg_reg  <= pg_inc;
                    unique case (op_reg)
                        OP_FREE:
                        begin
                            if (!bit_cur)
                            begin
                                if (status_reg == STS_OK)
                                begin
                                    status_reg <= STS_DOUBLE;
                                end
                            end
                            else
                            begin
                                free_reg    <= sat_inc(free_reg);
                                used_reg    <= sat_dec(used_reg);
                                changed_reg <= sat_inc(changed_reg);
                            end
                        end
                        OP_RESERVE:
                        begin
                            if (!bit_cur)
                            begin
                                free_reg    <= sat_dec(free_reg);
                                rsvd_reg    <= sat_inc(rsvd_reg);
                                changed_reg <= sat_inc(changed_reg);
                            end
                        end
                        OP_MARK:
                        begin
                            free_reg <= sat_inc(free_reg);
                            if (bit_cur)
                            begin
                                changed_reg <= sat_inc(changed_reg);
                            end
                        end
                        OP_ALLOC:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                    if (pm_last)
                    begin
                        state_reg <= S_PRD;
                    end
                end
                S_SRD:
                begin
                    if (sw_reg == (WA_W + 1)'(WORDS))
                    begin
                        status_reg <= STS_NOMEM;
                        state_reg  <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_SWAIT;
                    end
                end
                S_SWAIT:
                begin
                    buf_reg   <= ram_rdata;
                    bidx_reg  <= '0;
                    state_reg <= S_SEXAM;
                end
                S_SEXAM:
                begin
                    priority if (buf_reg == '1)
                    begin
                        run_reg   <= '0;
                        sw_reg    <= sw_reg + 1'b1;
                        state_reg <= S_SRD;
                    end
                    else if (buf_reg == '0)
                    begin
                        start_reg <= st_word;
                        if (run_reg + RUN_W'(WORD_W) >= cnt_ext)
                        begin
                            pg_reg    <= ADDR_W'(st_word);
                            end_reg   <= ADDR_W'(st_word) + ADDR_W'(count_reg);
                            state_reg <= S_PRD;
                        end
                        else
                        begin
                            run_reg   <= run_reg + RUN_W'(WORD_W);
                            sw_reg    <= sw_reg + 1'b1;
                            state_reg <= S_SRD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SBIT;
                    end
                end
                S_SBIT:
                begin
                    if (!buf_reg[bidx_reg])
                    begin
                        start_reg <= st_bit;
                        run_reg   <= run_reg + 1'b1;
                    end
                    else
                    begin
                        run_reg <= '0;
                    end
                    if (!buf_reg[bidx_reg] && (run_reg + 1'b1 == cnt_ext))
                    begin
                        pg_reg    <= ADDR_W'(st_bit);
                        end_reg   <= ADDR_W'(st_bit) + ADDR_W'(count_reg);
                        state_reg <= S_PRD;
                    end
                    else if (bidx_reg == {BIT_W{1'b1}})
                    begin
                        sw_reg    <= sw_reg + 1'b1;
                        state_reg <= S_SRD;
                    end
                    else
                    begin
                        bidx_reg <= bidx_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg          <= 1'b1;
                        rsp_reg.status         <= status_reg;
                        rsp_reg.base_addr      <= grant ? (ADDR_W'(start_reg) << PAGE_BITS) : '0;
                        rsp_reg.pages_changed  <= grant ? count_reg : changed_reg;
                        rsp_reg.free_count     <= grant ? free_dec : free_reg;
                        rsp_reg.used_count     <= grant ? used_inc : used_reg;
                        rsp_reg.reserved_count <= rsvd_reg;
                        if (grant)
                        begin
                            // bulk counter update for a granted run
                            free_reg <= free_dec;
                            used_reg <= used_inc;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/bitmap_page_frame_allocator.sv]
// Top level of the bitmap page frame allocator: front classifier, job queue, back executor.
// Depends on bpfa_pkg, bpfa_front, bpfa_back (and bpfa_ram below it).
//
// Request beats (req/req_valid/req_stall) carry one operation each: allocate
// run, free pages, reserve byte region, mark pages usable. Response beats
// (rsp/rsp_valid/rsp_stall) come back one per request, in order, with status,
// base address and the three counters. A beat moves when valid is high and
// stall is low at a rising edge.
// Map access: the page map is a 64-bit-wide RAM. Free/reserve/mark walk it one
// page per cycle within a map word, after a read and a capture step for each
// word; the write-back rides on the last page of the word.
// Allocation scans word by word: each word is read, captured and examined, a
// mixed one then bit by bit, and the granted run is marked the same way.
// One job runs at a time; a two-entry queue takes new requests meanwhile.
// Reset: rst_n clears counters and control, then the map is filled with all-used
// words, one per cycle, with req_stall high.
// Receiver stall: a held rsp_stall keeps the result registered; the next job
// finishes its map work and waits, the queue fills, then req_stall rises.
`default_nettype none

module bitmap_page_frame_allocator #(
    parameter int PAGE_TOTAL = 32768,
    parameter int PAGE_BITS  = 12
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire bpfa_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output bpfa_pkg::rsp_t       rsp
);
    import bpfa_pkg::*;

    job_t job;
    logic job_valid;
    logic job_pop;
    logic clearing;

    bpfa_front #(
        .PAGE_BITS(PAGE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .clearing (clearing),
        .job_valid(job_valid),
        .job      (job),
        .job_pop  (job_pop)
    );

    bpfa_back #(
        .PAGE_TOTAL(PAGE_TOTAL),
        .PAGE_BITS (PAGE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(job_valid),
        .job      (job),
        .job_pop  (job_pop),
        .clearing (clearing),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire
